[hw/rtl/bphe_pkg.sv]
// shared types and constants for the button press / release / hold event block
// no dependencies; imported by every module of the block

package bphe_pkg;

   // field widths
   localparam int LEVEL_W = 4;
   localparam int EVENT_W = 4;
   localparam int TIME_W  = 32;
   localparam int HOLD_W  = 8;
   localparam int EN_W    = 4;

   // default switch count
   localparam int SWITCH_COUNT_DEF = 4;

   // register file geometry
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_SECONDS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DOWN_ENABLE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_UP_ENABLE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_ENABLE  = 2'd3;

   // register reset values
   localparam logic [HOLD_W-1:0] HOLD_SECONDS_RST = 8'd2;
   localparam logic [EN_W-1:0]   DOWN_ENABLE_RST  = 4'd0;
   localparam logic [EN_W-1:0]   UP_ENABLE_RST    = 4'd15;
   localparam logic [EN_W-1:0]   HOLD_ENABLE_RST  = 4'd8;

   // configuration seen by the detector
   typedef struct packed {
      logic [HOLD_W-1:0] hold_seconds;
      logic [EN_W-1:0]   down_enable;
      logic [EN_W-1:0]   up_enable;
      logic [EN_W-1:0]   hold_enable;
   } cfg_type;

endpackage

[hw/rtl/bphe_csr.sv]
// configuration registers behind an apb-style port
// depends on bphe_pkg

module bphe_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bphe_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bphe_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bphe_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output bphe_pkg::cfg_type                cfg
);
   import bphe_pkg::*;

   logic [HOLD_W-1:0]    hold_seconds_ff;
   logic [EN_W-1:0]      down_enable_ff;
   logic [EN_W-1:0]      up_enable_ff;
   logic [EN_W-1:0]      hold_enable_ff;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_IDX_W+1:2];
   assign wr_en   = psel & penable & pwrite & pready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_seconds_ff <= HOLD_SECONDS_RST;
         down_enable_ff  <= DOWN_ENABLE_RST;
         up_enable_ff    <= UP_ENABLE_RST;
         hold_enable_ff  <= HOLD_ENABLE_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_HOLD_SECONDS: hold_seconds_ff <= pwdata[HOLD_W-1:0];
            REG_DOWN_ENABLE:  down_enable_ff  <= pwdata[EN_W-1:0];
            REG_UP_ENABLE:    up_enable_ff    <= pwdata[EN_W-1:0];
            REG_HOLD_ENABLE:  hold_enable_ff  <= pwdata[EN_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_HOLD_SECONDS: prdata = {{(CSR_DATA_W-HOLD_W){1'b0}}, hold_seconds_ff};
         REG_DOWN_ENABLE:  prdata = {{(CSR_DATA_W-EN_W){1'b0}}, down_enable_ff};
         REG_UP_ENABLE:    prdata = {{(CSR_DATA_W-EN_W){1'b0}}, up_enable_ff};
         REG_HOLD_ENABLE:  prdata = {{(CSR_DATA_W-EN_W){1'b0}}, hold_enable_ff};
         default:          prdata = '0;
      endcase
   end

   assign cfg.hold_seconds = hold_seconds_ff;
   assign cfg.down_enable  = down_enable_ff;
   assign cfg.up_enable    = up_enable_ff;
   assign cfg.hold_enable  = hold_enable_ff;

endmodule

[hw/rtl/bphe_detect.sv]
// per-switch edge and hold detection with its state registers
// depends on bphe_pkg

module bphe_detect #(
   parameter int SWITCH_COUNT = bphe_pkg::SWITCH_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [SWITCH_COUNT-1:0]         levels,
   input  logic [bphe_pkg::TIME_W-1:0]     now,
   input  bphe_pkg::cfg_type               cfg,
   output logic [SWITCH_COUNT-1:0]         press,
   output logic [SWITCH_COUNT-1:0]         release_ev,
   output logic [SWITCH_COUNT-1:0]         hold
);
   import bphe_pkg::*;

   logic [SWITCH_COUNT-1:0] prev_levels_ff;
   logic [SWITCH_COUNT-1:0] seen_ff;
   logic [SWITCH_COUNT-1:0] fired_ff;
   logic [TIME_W-1:0]       change_time_ff [SWITCH_COUNT];

   logic [SWITCH_COUNT-1:0] seen_in;
   logic [SWITCH_COUNT-1:0] fired_in;
   logic [TIME_W-1:0]       change_time_in [SWITCH_COUNT];
   logic [SWITCH_COUNT-1:0] changed;
   logic [SWITCH_COUNT-1:0] down_en;
   logic [SWITCH_COUNT-1:0] up_en;
   logic [SWITCH_COUNT-1:0] hold_en;
   logic [TIME_W-1:0]       hold_limit;

   assign hold_limit = {{(TIME_W-HOLD_W){1'b0}}, cfg.hold_seconds};
   assign changed    = levels ^ prev_levels_ff;

   genvar i;
   generate
      for (i = 0; i < SWITCH_COUNT; i++) begin : g_sw
         logic [TIME_W-1:0] elapsed;

         // enables exist only for switches covered by the register fields
         if (i < EN_W) begin : g_en
            assign down_en[i] = cfg.down_enable[i];
            assign up_en[i]   = cfg.up_enable[i];
            assign hold_en[i] = cfg.hold_enable[i];
         end else begin : g_noen
            assign down_en[i] = 1'b0;
            assign up_en[i]   = 1'b0;
            assign hold_en[i] = 1'b0;
         end

         // change time after this poll
         assign change_time_in[i] = changed[i] ? now : change_time_ff[i];
         assign seen_in[i]        = seen_ff[i] | changed[i];
         assign elapsed           = now - change_time_in[i];

         // edge events
         assign press[i]      = changed[i] & ~levels[i] & down_en[i];
         assign release_ev[i] = changed[i] & levels[i] & up_en[i] & ~fired_ff[i];

         // hold event once per press
         assign hold[i] = ~levels[i] & seen_in[i] & (elapsed >= hold_limit)
                          & ~fired_ff[i] & hold_en[i];

         // hold mark cleared by release, set by hold
         assign fired_in[i] = (changed[i] & levels[i]) ? 1'b0 : (fired_ff[i] | hold[i]);

         // state update per poll
         always_ff @(posedge clock) begin
            if (reset) begin
               change_time_ff[i] <= '0;
            end else if (step) begin
               change_time_ff[i] <= change_time_in[i];
            end
         end
      end
   endgenerate

   // level and flag state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_levels_ff <= '1;
         seen_ff        <= '0;
         fired_ff       <= '0;
      end else if (step) begin
         prev_levels_ff <= levels;
         seen_ff        <= seen_in;
         fired_ff       <= fired_in;
      end
   end

endmodule

[hw/rtl/button_press_release_hold_events.sv]
// button press / release / hold event detector, top level
// a beat accepted into the input register passes the detector into the result register
// throughput: one beat per cycle while the result side does not stall, set by the single-pass detector stage
// stalls on the result side hold both the result and the input register
// reset: synchronous, active high; switches read released, no change times
// depends on bphe_pkg, bphe_csr, bphe_detect

module button_press_release_hold_events #(
   parameter int SWITCH_COUNT = bphe_pkg::SWITCH_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bphe_pkg::LEVEL_W-1:0]     req_switch_levels,
   input  logic [bphe_pkg::TIME_W-1:0]      req_current_seconds,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bphe_pkg::EVENT_W-1:0]     rsp_press_events,
   output logic [bphe_pkg::EVENT_W-1:0]     rsp_release_events,
   output logic [bphe_pkg::EVENT_W-1:0]     rsp_hold_events,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bphe_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bphe_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bphe_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import bphe_pkg::*;

   cfg_type cfg;

   logic                    in_valid_ff;
   logic [LEVEL_W-1:0]      in_levels_ff;
   logic [TIME_W-1:0]       in_seconds_ff;
   logic                    out_valid_ff;
   logic [EVENT_W-1:0]      press_ff;
   logic [EVENT_W-1:0]      release_ff;
   logic [EVENT_W-1:0]      hold_ff;
   logic [EVENT_W-1:0]      press_in;
   logic [EVENT_W-1:0]      release_in;
   logic [EVENT_W-1:0]      hold_in;
   logic                    advance;
   logic                    step;
   logic [SWITCH_COUNT-1:0] sw_levels;
   logic [SWITCH_COUNT-1:0] sw_press;
   logic [SWITCH_COUNT-1:0] sw_release;
   logic [SWITCH_COUNT-1:0] sw_hold;

   bphe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // handshake: result register frees, input register moves on
   assign advance   = ~out_valid_ff | rsp_ready;
   assign step      = in_valid_ff & advance;
   assign req_ready = ~in_valid_ff | advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         in_levels_ff  <= req_switch_levels;
         in_seconds_ff <= req_current_seconds;
      end
   end

   // map field bits onto switches; switches beyond the field read pressed
   genvar i;
   generate
      for (i = 0; i < SWITCH_COUNT; i++) begin : g_lvl
         if (i < LEVEL_W) begin : g_in
            assign sw_levels[i] = in_levels_ff[i];
         end else begin : g_zero
            assign sw_levels[i] = 1'b0;
         end
      end
      for (i = 0; i < EVENT_W; i++) begin : g_evt
         if (i < SWITCH_COUNT) begin : g_on
            assign press_in[i]   = sw_press[i];
            assign release_in[i] = sw_release[i];
            assign hold_in[i]    = sw_hold[i];
         end else begin : g_off
            assign press_in[i]   = 1'b0;
            assign release_in[i] = 1'b0;
            assign hold_in[i]    = 1'b0;
         end
      end
   endgenerate

   bphe_detect #(
      .SWITCH_COUNT (SWITCH_COUNT)
   ) u_detect (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .levels     (sw_levels),
      .now        (in_seconds_ff),
      .cfg        (cfg),
      .press      (sw_press),
      .release_ev (sw_release),
      .hold       (sw_hold)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         press_ff   <= press_in;
         release_ff <= release_in;
         hold_ff    <= hold_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_press_events   = press_ff;
   assign rsp_release_events = release_ff;
   assign rsp_hold_events    = hold_ff;

endmodule
